@@ hdl/sss_pkg.sv @@
// Shared types, constants and glyph table for the seven-segment scan serializer.
package sss_pkg;

    localparam int SEG_W   = 8;
    localparam int SEL_W   = 8;
    localparam int WORD_W  = SEG_W + SEL_W;
    localparam int BIN_W   = 14;
    localparam int BCD_W   = 16;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 8;

    localparam logic [15:0] NUM_MAX   = 16'd9999;
    localparam logic [15:0] CODE_LIM  = 16'd16;
    localparam logic [7:0]  DOT_MASK  = 8'h80;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_CHAR    = 2'd0;
    localparam opcode_t OP_NUMBER  = 2'd1;
    localparam opcode_t OP_REFRESH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BCD,
        ST_WRNUM,
        ST_SEARCH,
        ST_READ,
        ST_LOAD
    } ctl_state_t;

    function automatic logic [7:0] glyph(input logic [3:0] code);
        logic [7:0] g;
        case (code)
            4'h0:    g = 8'h3F;
            4'h1:    g = 8'h06;
            4'h2:    g = 8'h5B;
            4'h3:    g = 8'h4F;
            4'h4:    g = 8'h66;
            4'h5:    g = 8'h6D;
            4'h6:    g = 8'h7D;
            4'h7:    g = 8'h07;
            4'h8:    g = 8'h7F;
            4'h9:    g = 8'h6F;
            4'hA:    g = 8'h79;  // E
            4'hB:    g = 8'h50;  // r
            4'hC:    g = 8'h40;  // -
            4'hD:    g = 8'h54;  // n
            4'hE:    g = 8'h5C;  // o
            4'hF:    g = 8'h73;  // P
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // active-low cathodes
    function automatic logic [7:0] seg_pattern(input logic [3:0] code, input logic dot);
        logic [7:0] p;
        p = glyph(code) | (dot ? DOT_MASK : 8'h00);
        return ~p;
    endfunction

endpackage

@@ hdl/seven_segment_scan_serializer.sv @@
// Top level: command decode, digit store, scan pointer and serializer control.
// Usage notes
// Input stream s_*: one item per command. s_tuser is the opcode (write character,
// write four-digit number line, refresh tick). Output stream m_*: one item per
// serial bit, sixteen per refresh, MSB first: segment byte then one-hot select.
// A character write goes straight into the store. A number write runs a
// bit-serial BCD conversion, then writes its four digits one per cycle. A refresh
// steps the pointer one candidate digit per cycle until it finds an active digit,
// reads the store into a register, then hands the 16-bit word to the serializer,
// which sends one bit per cycle while m_tready is high. The next item is taken as
// soon as the word has been handed over; a further refresh waits for the
// serializer to empty.
// Reset clears the active mask and pointer: no digit active, refresh ticks
// produce nothing until a digit is written. When m_tready is low the output
// register holds its bit and the shift register waits.
module seven_segment_scan_serializer
    import sss_pkg::*;
#(
    parameter int NUM_DIGITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [3:0] digit_position, [19:4] operand_value,
                                        // [20] dot_on, [21] line_select, [23:22] zero
    input  logic [1:0]       s_tuser,   // opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [0] serial_bit, [7:1] zero
    output logic             m_tuser,   // is_select_byte
    output logic             m_tlast    // last_bit
);

    localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    ctl_state_t state_reg, state_next;

    logic [NUM_DIGITS-1:0] mask_reg, mask_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [PW-1:0]         cand_reg, cand_next;
    logic                  base_reg, base_next;
    logic [1:0]            cnt_reg, cnt_next;

    logic [SEG_W-1:0]      store_mem [NUM_DIGITS];
    logic [SEG_W-1:0]      rdata_reg;

    logic                  we;
    logic [PW-1:0]         wa;
    logic [SEG_W-1:0]      wd;

    logic [3:0]            in_digit;
    logic [15:0]           in_operand;
    logic                  in_dot;
    logic                  in_line;

    logic                  bcd_start;
    logic                  bcd_done;
    logic [BCD_W-1:0]      bcd_val;
    logic [3:0]            num_digit;
    logic [3:0]            num_nib;

    logic [PW-1:0]         ptr_inc;
    logic [PW-1:0]         cand_inc;

    logic                  ser_load;
    logic                  ser_ready;
    logic [SEL_W-1:0]      sel_byte;

    assign in_digit   = s_tdata[3:0];
    assign in_operand = s_tdata[19:4];
    assign in_dot     = s_tdata[20];
    assign in_line    = s_tdata[21];

    assign s_tready = (state_reg == ST_IDLE);

    assign ptr_inc  = (ptr_reg == PW'(NUM_DIGITS - 1)) ? '0 : ptr_reg + 1'b1;
    assign cand_inc = (cand_reg == PW'(NUM_DIGITS - 1)) ? '0 : cand_reg + 1'b1;

    assign num_digit = {1'b0, base_reg, cnt_reg};
    assign sel_byte  = SEL_W'(1) << ptr_reg;

    // thousands go to the lowest digit of the line
    always_comb
    begin
        case (cnt_reg)
            2'd0:    num_nib = bcd_val[15:12];
            2'd1:    num_nib = bcd_val[11:8];
            2'd2:    num_nib = bcd_val[7:4];
            2'd3:    num_nib = bcd_val[3:0];
            default: num_nib = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mask_next  = mask_reg;
        ptr_next   = ptr_reg;
        cand_next  = cand_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        we         = 1'b0;
        wa         = '0;
        wd         = '0;
        bcd_start  = 1'b0;
        ser_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        OP_CHAR:
                        begin
                            if (in_digit < 4'(NUM_DIGITS) && in_operand < CODE_LIM)
                            begin
                                we        = 1'b1;
                                wa        = in_digit[PW-1:0];
                                wd        = seg_pattern(in_operand[3:0], in_dot);
                                mask_next = mask_reg | (NUM_DIGITS'(1) << wa);
                            end
                        end
                        OP_NUMBER:
                        begin
                            if (in_operand <= NUM_MAX)
                            begin
                                bcd_start  = 1'b1;
                                base_next  = in_line;
                                state_next = ST_BCD;
                            end
                        end
                        OP_REFRESH:
                        begin
                            if (mask_reg != '0)
                            begin
                                cand_next  = ptr_inc;
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_BCD:
            begin
                if (bcd_done)
                begin
                    cnt_next   = '0;
                    state_next = ST_WRNUM;
                end
            end
            ST_WRNUM:
            begin
                if (num_digit < 4'(NUM_DIGITS))
                begin
                    we        = 1'b1;
                    wa        = num_digit[PW-1:0];
                    wd        = seg_pattern(num_nib, 1'b0);
                    mask_next = mask_reg | (NUM_DIGITS'(1) << wa);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (mask_reg[cand_reg])
                begin
                    ptr_next   = cand_reg;
                    state_next = ST_READ;
                end
                else
                begin
                    cand_next = cand_inc;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (ser_ready)
                begin
                    ser_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg  <= '0;
            ptr_reg   <= '0;
            cand_reg  <= '0;
            base_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            ptr_reg   <= ptr_next;
            cand_reg  <= cand_next;
            base_reg  <= base_next;
            cnt_reg   <= cnt_next;
        end
    end

    // only digits marked active are ever read, so the store needs no clearing
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        rdata_reg <= store_mem[ptr_reg];
    end

    sss_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (in_operand[BIN_W-1:0]),
        .done  (bcd_done),
        .bcd   (bcd_val)
    );

    sss_shift u_shift (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ser_load),
        .word     ({rdata_reg, sel_byte}),
        .ready    (ser_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_search_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (mask_reg != '0))
        else $error("pointer search with no active digit");
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ser_load |-> ser_ready)
        else $error("serializer loaded while busy");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PW'(NUM_DIGITS - 1))
        else $error("scan pointer out of range");
`endif

endmodule

@@ hdl/sss_bcd.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module sss_bcd
    import sss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [BIN_W-1:0] value,
    output logic             done,
    output logic [BCD_W-1:0] bcd
);

    localparam int CNT_W = $clog2(BIN_W);

    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int n = 0; n < BCD_W / 4; n++)
        begin
            adj[n*4 +: 4] = (bcd_reg[n*4 +: 4] >= 4'd5) ? bcd_reg[n*4 +: 4] + 4'd3
                                                        : bcd_reg[n*4 +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_next = {bin_reg[BIN_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(BIN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ hdl/sss_shift.sv @@
// Output serializer: 16-bit shift register feeding a registered stream output.
module sss_shift
    import sss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [WORD_W-1:0] word,
    output logic              ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [0] serial_bit, rest zero
    output logic              m_tuser,   // is_select_byte
    output logic              m_tlast    // last_bit
);

    localparam int IDX_W = $clog2(WORD_W);

    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              busy_reg, busy_next;
    logic              vld_reg, vld_next;
    logic              bit_reg, bit_next;
    logic              sel_reg, sel_next;
    logic              last_reg, last_next;
    logic              out_free;

    assign out_free = !vld_reg || m_tready;

    always_comb
    begin
        shift_next = shift_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        vld_next   = vld_reg && !m_tready;
        bit_next   = bit_reg;
        sel_next   = sel_reg;
        last_next  = last_reg;
        if (load)
        begin
            shift_next = word;
            idx_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg && out_free)
        begin
            vld_next   = 1'b1;
            bit_next   = shift_reg[WORD_W-1];
            sel_next   = idx_reg >= IDX_W'(SEG_W);
            last_next  = idx_reg == IDX_W'(WORD_W - 1);
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            idx_next   = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bit_reg   <= bit_next;
        sel_reg   <= sel_next;
        last_reg  <= last_next;
    end

    assign ready    = !busy_reg;
    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(OUT_W-1){1'b0}}, bit_reg};
    assign m_tuser  = sel_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_reg)
        else $error("serializer loaded while busy");
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg)
        else $error("load did not start serializer");
    a_last_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && last_reg) |-> sel_reg)
        else $error("last bit outside select byte");
`endif

endmodule
